[rtl/rbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared constants, types and helpers of the run-length byte compressor.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int unsigned MAX_LITERAL = 127;
  localparam int unsigned MAX_RUN     = 129;

  // Count and index widths of the literal store and the run counter
  localparam int unsigned LIT_AW = $clog2(MAX_LITERAL + 1);
  localparam int unsigned RUN_W  = $clog2(MAX_RUN + 1);

  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned CNT_W      = $clog2(WORD_BYTES + 1);

  // Header forms
  localparam logic [31:0] SHORT_LEN_MAX = 32'h0000_FFFF;
  localparam logic [15:0] LONG_HDR_FLAG = 16'h0008;

  // Configuration register map (word index)
  localparam logic [0:0] REG_TOTAL_LENGTH = 1'b0;
  localparam int unsigned APB_AW = 3;

  // One code segment: a head byte, a number of bytes read from the literal
  // store, then an optional trailing byte.
  typedef struct packed {
    logic              en;
    logic [7:0]        head;
    logic [LIT_AW-1:0] ram_n;
    logic              tail;
    logic [7:0]        tail_byte;
  } rbc_seg_t;

  // Everything one accepted byte asks the emitter to produce
  typedef struct packed {
    logic        hdr_en;
    logic        hdr_long;
    logic [31:0] len;
    rbc_seg_t    seg0;
    rbc_seg_t    seg1;
    logic        last;
  } rbc_plan_t;

  // Byte lane from emitter to packer
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       flush;
    logic       last;
  } rbc_bytes_t;

  // Packer status back to the emitter
  typedef struct packed {
    logic ready;
    logic empty;
  } rbc_pack_status_t;

  function automatic rbc_seg_t run_seg(input logic [RUN_W-1:0] len,
                                       input logic [7:0] value);
    rbc_seg_t s;
    s.en        = 1'b1;
    s.head      = 8'(len - RUN_W'(2));
    s.ram_n     = '0;
    s.tail      = 1'b1;
    s.tail_byte = value;
    return s;
  endfunction

  // Literal block of n_ram stored bytes plus an optional trailing byte;
  // head is the negated block length.
  function automatic rbc_seg_t lit_seg(input logic [LIT_AW-1:0] n_ram,
                                       input logic has_tail,
                                       input logic [7:0] tail_byte);
    rbc_seg_t          s;
    logic [LIT_AW-1:0] cnt;
    cnt         = n_ram + LIT_AW'(has_tail);
    s.en        = 1'b1;
    s.head      = 8'(8'd0 - 8'(cnt));
    s.ram_n     = n_ram;
    s.tail      = has_tail;
    s.tail_byte = tail_byte;
    return s;
  endfunction

endpackage

[rtl/rbc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 127
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data between reads
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rbc_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_emit
// Byte sequencer: walks header, code segments and literal store reads,
// handing one code byte per cycle to the packer while the packer has room.
// ----------------------------------------------------------------------------
module rbc_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  rbc_pkg::rbc_plan_t         plan,
  output logic                       idle,
  output logic                       rd_en,
  output logic [rbc_pkg::LIT_AW-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  output rbc_pkg::rbc_bytes_t        bytes_out,
  input  rbc_pkg::rbc_pack_status_t  pstat
);

  import rbc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_HEAD,
    ST_RAM,
    ST_TAIL,
    ST_FLUSH
  } state_t;

  state_t            state;
  rbc_plan_t         plan_q;
  logic              sel;
  logic [2:0]        idx;
  logic [LIT_AW-1:0] ridx;
  logic              rd_issued;

  rbc_seg_t          cur;
  logic [63:0]       hdr_word;
  logic [2:0]        hdr_end;
  logic [LIT_AW-1:0] ridx_end;
  logic              more_seg;

  assign cur      = sel ? plan_q.seg1 : plan_q.seg0;
  assign hdr_word = plan_q.hdr_long ? {LONG_HDR_FLAG, 16'h0000, plan_q.len}
                                    : {16'h0000, plan_q.len[15:0], 32'h0};
  assign hdr_end  = plan_q.hdr_long ? 3'd7 : 3'd3;
  assign ridx_end = cur.ram_n - LIT_AW'(1);
  assign more_seg = !sel && plan_q.seg1.en;
  assign idle     = (state == ST_IDLE);

  always_comb begin
    bytes_out       = '0;
    bytes_out.flush = (state == ST_FLUSH);
    bytes_out.last  = plan_q.last;
    rd_en           = 1'b0;
    rd_addr         = ridx;
    case (state)
      ST_HDR: begin
        bytes_out.valid = pstat.ready;
        bytes_out.data  = hdr_word[{~idx, 3'b000} +: 8];
      end
      ST_HEAD: begin
        bytes_out.valid = pstat.ready;
        bytes_out.data  = cur.head;
      end
      ST_RAM: begin
        bytes_out.data = rd_data;
        if (!rd_issued) begin
          rd_en = 1'b1;
        end else if (pstat.ready) begin
          bytes_out.valid = 1'b1;
          // fetch the next entry while this one is taken
          if (ridx != ridx_end) begin
            rd_en   = 1'b1;
            rd_addr = ridx + LIT_AW'(1);
          end
        end
      end
      ST_TAIL: begin
        bytes_out.valid = pstat.ready;
        bytes_out.data  = cur.tail_byte;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= 1'b0;
      idx       <= '0;
      ridx      <= '0;
      rd_issued <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            plan_q <= plan;
            idx    <= '0;
            if (plan.hdr_en) begin
              state <= ST_HDR;
            end else if (plan.seg0.en) begin
              sel   <= 1'b0;
              state <= ST_HEAD;
            end else if (plan.seg1.en) begin
              sel   <= 1'b1;
              state <= ST_HEAD;
            end
          end
        end
        ST_HDR: begin
          if (pstat.ready) begin
            if (idx == hdr_end) begin
              if (plan_q.seg0.en) begin
                sel   <= 1'b0;
                state <= ST_HEAD;
              end else if (plan_q.seg1.en) begin
                sel   <= 1'b1;
                state <= ST_HEAD;
              end else begin
                state <= ST_FLUSH;
              end
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        ST_HEAD: begin
          if (pstat.ready) begin
            if (cur.ram_n != '0) begin
              ridx      <= '0;
              rd_issued <= 1'b0;
              state     <= ST_RAM;
            end else if (cur.tail) begin
              state <= ST_TAIL;
            end else if (more_seg) begin
              sel   <= 1'b1;
              state <= ST_HEAD;
            end else begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_RAM: begin
          if (!rd_issued) begin
            rd_issued <= 1'b1;
          end else if (pstat.ready) begin
            if (ridx == ridx_end) begin
              rd_issued <= 1'b0;
              if (cur.tail) begin
                state <= ST_TAIL;
              end else if (more_seg) begin
                sel   <= 1'b1;
                state <= ST_HEAD;
              end else begin
                state <= ST_FLUSH;
              end
            end else begin
              ridx <= ridx + LIT_AW'(1);
            end
          end
        end
        ST_TAIL: begin
          if (pstat.ready) begin
            if (more_seg) begin
              sel   <= 1'b1;
              state <= ST_HEAD;
            end else begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (pstat.empty) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_ram_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RAM) |-> (cur.ram_n != '0) && (ridx < cur.ram_n))
    else $error("literal read index outside block");

endmodule

[rtl/rbc_pack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_pack
// Packs code bytes into eight-byte words, first byte highest, and holds
// each word in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module rbc_pack (
  input  logic                      clk,
  input  logic                      rst,
  input  rbc_pkg::rbc_bytes_t       bytes_in,
  output rbc_pkg::rbc_pack_status_t pstat,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [71:0]               m_axis_tdata,  // out_bytes[63:0], out_count[67:64]
  output logic                      m_axis_tlast   // out_last
);

  import rbc_pkg::*;

  logic [63:0]      acc;
  logic [CNT_W-1:0] acnt;
  logic [63:0]      out_bytes;
  logic [CNT_W-1:0] out_count;
  logic             out_last;
  logic             out_free;
  logic             push;

  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign push        = out_free && ((acnt == CNT_W'(WORD_BYTES))
                                    || (bytes_in.flush && acnt != '0));
  assign pstat.ready = (acnt < CNT_W'(WORD_BYTES));
  assign pstat.empty = (acnt == '0);

  assign m_axis_tdata = {4'b0000, out_count, out_bytes};
  assign m_axis_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      acnt          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (push) begin
        m_axis_tvalid <= 1'b1;
        out_bytes     <= acc;
        out_count     <= acnt;
        out_last      <= bytes_in.flush && bytes_in.last;
        acc           <= '0;
        acnt          <= '0;
      end else begin
        if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
        end
        if (bytes_in.valid) begin
          acc[{~acnt[2:0], 3'b000} +: 8] <= bytes_in.data;
          acnt                           <= acnt + CNT_W'(1);
        end
      end
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (rst)
    acnt <= CNT_W'(WORD_BYTES))
    else $error("packer overfilled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_count != '0) && (out_count <= CNT_W'(WORD_BYTES)))
    else $error("result with bad byte count");

endmodule

[rtl/rle_byte_compressor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_byte_compressor_unit
// Run-length byte compressor: header, runs and literal blocks, packed into
// eight-byte results. Literal bytes wait in a synchronous RAM.
//
//   channel   dir  payload                              handshake
//   s_axis    in   tdata[7:0] in_byte                   tvalid/tready
//   m_axis    out  tdata[63:0] out_bytes,               tvalid/tready
//                  tdata[67:64] out_count, tlast out_last
//   apb       in   paddr 0: total_length (32 bits)      psel/penable, pready=1
//
// A byte that produces no code is taken without a stall. A byte that produces
// code holds s_axis_tready low until the emitter is idle again, that is until
// its code bytes are packed and its last output word is registered, since the
// emitter drives one byte a cycle while the packer has room and the literal
// RAM has one read port.
// m_axis_tready low stalls the packer and with it the emitter.
// Reset is synchronous; the literal RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module rle_byte_compressor_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // in_byte[7:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [71:0]                m_axis_tdata,   // out_bytes[63:0], out_count[67:64]
  output logic                       m_axis_tlast,   // out_last
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import rbc_pkg::*;

  logic [31:0]       total_length;
  logic [7:0]        pending_byte;
  logic [7:0]        pending_byte_next;
  logic              pending_valid;
  logic              pending_valid_next;
  logic [LIT_AW-1:0] literal_count;
  logic [LIT_AW-1:0] literal_count_next;
  logic [RUN_W-1:0]  run_length;
  logic [RUN_W-1:0]  run_length_next;
  logic [31:0]       bytes_seen;
  logic [31:0]       bytes_seen_next;

  logic              accept;
  logic              cfg_wr;
  logic              end_now;
  logic              lit_we;
  logic [7:0]        in_byte;
  rbc_plan_t         plan;

  logic              emit_idle;
  logic              rd_en;
  logic [LIT_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  rbc_bytes_t        byte_lane;
  rbc_pack_status_t  pstat;

  assign in_byte       = s_axis_tdata;
  assign s_axis_tready = emit_idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TOTAL_LENGTH) ? total_length : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= 32'd1;
    end else if (cfg_wr && paddr[2] == REG_TOTAL_LENGTH) begin
      total_length <= pwdata;
    end
  end

  assign bytes_seen_next = bytes_seen + 32'd1;
  assign end_now         = (bytes_seen_next == total_length);

  // Classify the new byte and plan the code it releases
  always_comb begin
    plan               = '0;
    pending_byte_next  = pending_byte;
    pending_valid_next = pending_valid;
    literal_count_next = literal_count;
    run_length_next    = run_length;
    lit_we             = 1'b0;

    if (run_length != '0) begin
      if (in_byte == pending_byte && run_length < RUN_W'(MAX_RUN)) begin
        run_length_next = run_length + RUN_W'(1);
      end else begin
        plan.seg0          = run_seg(run_length, pending_byte);
        run_length_next    = '0;
        pending_byte_next  = in_byte;
        pending_valid_next = 1'b1;
      end
    end else if (pending_valid) begin
      if (in_byte == pending_byte) begin
        if (literal_count != '0) begin
          plan.seg0 = lit_seg(literal_count, 1'b0, 8'h00);
        end
        literal_count_next = '0;
        run_length_next    = RUN_W'(2);
        pending_valid_next = 1'b0;
      end else begin
        // store the pending byte; cut the block once it is full
        lit_we = 1'b1;
        if (literal_count == LIT_AW'(MAX_LITERAL - 1)) begin
          plan.seg0          = lit_seg(LIT_AW'(MAX_LITERAL), 1'b0, 8'h00);
          literal_count_next = '0;
        end else begin
          literal_count_next = literal_count + LIT_AW'(1);
        end
        pending_byte_next = in_byte;
      end
    end else begin
      pending_byte_next  = in_byte;
      pending_valid_next = 1'b1;
    end

    // End of stream: close whatever is open
    if (end_now) begin
      if (run_length_next != '0) begin
        plan.seg1 = run_seg(run_length_next, pending_byte_next);
      end else if (pending_valid_next) begin
        plan.seg1 = lit_seg(literal_count_next, 1'b1, pending_byte_next);
      end else if (literal_count_next != '0) begin
        plan.seg1 = lit_seg(literal_count_next, 1'b0, 8'h00);
      end
    end

    plan.hdr_en   = (bytes_seen == 32'd0);
    plan.hdr_long = (total_length > SHORT_LEN_MAX);
    plan.len      = total_length;
    plan.last     = end_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte  <= '0;
      pending_valid <= 1'b0;
      literal_count <= '0;
      run_length    <= '0;
      bytes_seen    <= '0;
    end else if (accept) begin
      if (end_now) begin
        pending_byte  <= '0;
        pending_valid <= 1'b0;
        literal_count <= '0;
        run_length    <= '0;
        bytes_seen    <= '0;
      end else begin
        pending_byte  <= pending_byte_next;
        pending_valid <= pending_valid_next;
        literal_count <= literal_count_next;
        run_length    <= run_length_next;
        bytes_seen    <= bytes_seen_next;
      end
    end
  end

  rbc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LITERAL)
  ) u_literal_ram (
    .clk     (clk),
    .wr_en   (accept && lit_we),
    .wr_addr (literal_count),
    .wr_data (pending_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rbc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .plan      (plan),
    .idle      (emit_idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .bytes_out (byte_lane),
    .pstat     (pstat)
  );

  rbc_pack u_pack (
    .clk           (clk),
    .rst           (rst),
    .bytes_in      (byte_lane),
    .pstat         (pstat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_run_range: assert property (@(posedge clk) disable iff (rst)
    (run_length != RUN_W'(1)) && (run_length <= RUN_W'(MAX_RUN)))
    else $error("run length out of range");

  a_run_xor_pending: assert property (@(posedge clk) disable iff (rst)
    !(pending_valid && run_length != '0))
    else $error("pending byte held during a run");

  a_literal_room: assert property (@(posedge clk) disable iff (rst)
    literal_count < LIT_AW'(MAX_LITERAL))
    else $error("literal block not cut at its limit");

endmodule

[tb/rbc_code_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_code_checker
// Watches the byte, code and register ports of the run-length compressor,
// rebuilds the expected code words from every accepted byte and compares
// each delivered word, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module rbc_code_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [71:0]                m_axis_tdata,
  input  logic                       m_axis_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         errors,
  output int                         pending,
  output int                         words_seen
);

  import rbc_pkg::*;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
  } code_word_t;

  code_word_t  owed_words[$];
  logic [7:0]  code_bytes[$];
  code_word_t  oldest;

  // Encoder image
  logic [31:0] length_reg;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic [7:0]  lit_buf [MAX_LITERAL];
  int          lit_cnt;
  int          run_len;
  logic [31:0] seen;

  int          err_cnt  = 0;
  int          word_cnt = 0;

  assign errors     = err_cnt;
  assign words_seen = word_cnt;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h want %h (word %0d)", $realtime, what, got,
             want, word_cnt);
    err_cnt++;
  endtask

  task automatic clear_stream();
    held_byte  = '0;
    held_valid = 1'b0;
    lit_cnt    = 0;
    run_len    = 0;
    seen       = '0;
  endtask

  task automatic flush_literals();
    if (lit_cnt != 0) begin
      code_bytes.push_back(8'(256 - lit_cnt));
      for (int i = 0; i < lit_cnt; i++)
        code_bytes.push_back(lit_buf[i]);
      lit_cnt = 0;
    end
  endtask

  task automatic add_literal(input logic [7:0] b);
    if (lit_cnt < MAX_LITERAL) begin
      lit_buf[lit_cnt] = b;
      lit_cnt++;
    end
    if (lit_cnt >= MAX_LITERAL)
      flush_literals();
  endtask

  task automatic close_run();
    code_bytes.push_back(8'(run_len - 2));
    code_bytes.push_back(held_byte);
    run_len = 0;
  endtask

  task automatic encode_byte(input logic [7:0] b);
    bit          ends;
    int          nw;
    int          cnt;
    logic [63:0] w;
    code_word_t  cw;
    code_bytes.delete();
    ends = 1'b0;
    if (seen == '0) begin
      if (length_reg <= SHORT_LEN_MAX) begin
        code_bytes.push_back(8'h00);
        code_bytes.push_back(8'h00);
        code_bytes.push_back(length_reg[15:8]);
        code_bytes.push_back(length_reg[7:0]);
      end else begin
        code_bytes.push_back(LONG_HDR_FLAG[15:8]);
        code_bytes.push_back(LONG_HDR_FLAG[7:0]);
        code_bytes.push_back(8'h00);
        code_bytes.push_back(8'h00);
        code_bytes.push_back(length_reg[31:24]);
        code_bytes.push_back(length_reg[23:16]);
        code_bytes.push_back(length_reg[15:8]);
        code_bytes.push_back(length_reg[7:0]);
      end
    end

    if (run_len != 0) begin
      if (b == held_byte && run_len < MAX_RUN) begin
        run_len++;
      end else begin
        // run saturated or broken: the new byte starts over as pending
        close_run();
        held_byte  = b;
        held_valid = 1'b1;
      end
    end else if (held_valid) begin
      if (b == held_byte) begin
        flush_literals();
        run_len    = 2;
        held_valid = 1'b0;
      end else begin
        add_literal(held_byte);
        held_byte = b;
      end
    end else begin
      held_byte  = b;
      held_valid = 1'b1;
    end

    seen++;
    if (seen == length_reg) begin
      if (run_len != 0)
        close_run();
      else if (held_valid)
        add_literal(held_byte);
      flush_literals();
      clear_stream();
      ends = 1'b1;
    end

    // pack most significant byte first, zero the unused tail
    nw = (code_bytes.size() + 7) / 8;
    for (int k = 0; k < nw; k++) begin
      cnt = code_bytes.size() - 8 * k;
      if (cnt > 8)
        cnt = 8;
      w = '0;
      for (int i = 0; i < 8; i++)
        w = {w[55:0], (i < cnt) ? code_bytes[8 * k + i] : 8'h00};
      cw.bytes = w;
      cw.count = 4'(cnt);
      cw.last  = ends && (k == nw - 1);
      owed_words.push_back(cw);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      owed_words.delete();
      length_reg = 32'd1;
      clear_stream();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_TOTAL_LENGTH)
        length_reg = pwdata;
      if (s_axis_tvalid && s_axis_tready)
        encode_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        word_cnt++;
        if (owed_words.size() == 0) begin
          flag_mismatch("word with nothing owed", m_axis_tdata[63:0], '0);
        end else begin
          oldest = owed_words.pop_front();
          if (m_axis_tdata[63:0] !== oldest.bytes)
            flag_mismatch("out_bytes", m_axis_tdata[63:0], oldest.bytes);
          if (m_axis_tdata[67:64] !== oldest.count)
            flag_mismatch("out_count", 64'(m_axis_tdata[67:64]), 64'(oldest.count));
          if (m_axis_tlast !== oldest.last)
            flag_mismatch("out_last", 64'(m_axis_tlast), 64'(oldest.last));
        end
      end
      pending <= owed_words.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the run-length byte compressor. Directed streams
// cover both header forms, zero and extreme lengths and length changes
// mid-stream; random streams mix runs, literal blocks and noise with random
// gaps on both channels, a long output stall and saturated runs and blocks.
// ----------------------------------------------------------------------------
module tb;
  import rbc_pkg::*;

  localparam int unsigned         CYCLE_LIMIT       = 1_000_000;
  localparam int unsigned         RANDOM_BYTES      = 310;
  localparam int unsigned         SETTLE_CYCLES     = 16;
  localparam logic [APB_AW-1:0]   TOTAL_LENGTH_ADDR = {REG_TOTAL_LENGTH, 2'b00};

  typedef enum {SEG_RUN, SEG_LITERAL, SEG_NOISE} seg_kind_t;

  logic              clk;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [71:0]       m_axis_tdata;   // out_bytes[63:0], out_count[67:64]
  logic              m_axis_tlast;   // out_last
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  int          errors;
  int          pending;
  int          words_seen;

  bit          hold_go      = 1'b0;
  logic [31:0] cur_len      = 32'd1;
  int          bytes_sent   = 0;
  int          stream_cnt   = 0;
  int          length_writes = 0;

  rle_byte_compressor_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  rbc_code_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .errors        (errors),
    .pending       (pending),
    .words_seen    (words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d words owed", CYCLE_LIMIT, pending);
    $display("rle_byte_compressor_unit verification failed");
    $finish;
  end

  // Mostly back-to-back, some short gaps, the odd long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random back-pressure plus one long hold-off
  initial begin
    int g;
    wait (!rst);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (1000) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      g = idle_gap();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int g;
    g = idle_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Hold the sender until every owed word has arrived and the block settles
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [31:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOTAL_LENGTH_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cur_len = v;
    length_writes++;
  endtask

  task automatic random_stream(input bit long_run, input bit long_lit);
    logic [7:0] q[$];
    int         n;
    int         pos;
    logic [7:0] cur;
    logic [7:0] fill;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 24);
    // reuse the current length now and then so streams run back to back
    if (!long_run && !long_lit && cur_len <= 60 && $urandom_range(0, 2) == 0)
      n = cur_len;
    cur = 8'($urandom);
    while (q.size() < n) begin
      case (seg_kind_t'($urandom_range(0, 2)))
        SEG_RUN: begin
          repeat ($urandom_range(2, 9)) q.push_back(cur);
          cur = cur + 8'($urandom_range(1, 255));
        end
        SEG_LITERAL: begin
          repeat ($urandom_range(1, 8)) begin
            q.push_back(cur);
            cur = cur + 8'($urandom_range(1, 255));
          end
        end
        default: q.push_back(8'($urandom));
      endcase
    end
    while (q.size() > n) void'(q.pop_back());
    pos = $urandom_range(0, q.size() - 1);
    // one past the longest run, one past the longest literal block
    if (long_run) begin
      fill = 8'($urandom);
      repeat (MAX_RUN + 1) q.insert(pos, fill);
    end
    if (long_lit) begin
      fill = 8'($urandom);
      repeat (MAX_LITERAL + 1) begin
        q.insert(pos, fill);
        fill = fill + 8'($urandom_range(1, 255));
      end
    end
    if (q.size() != cur_len)
      set_length(q.size());
    // stall the receiver while this stream is still being offered
    if (long_run)
      hold_go = 1'b1;
    foreach (q[i]) push_byte(q[i]);
    stream_cnt++;
  endtask

  initial begin
    int start_bytes;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // length left at its reset value of one
    push_byte(8'h00);
    set_length(32'd1);
    push_byte(8'hFF);

    // largest short header, then end the stream early by shrinking the length
    set_length(32'h0000_FFFF);
    push_byte(8'hA5);
    push_byte(8'hA5);
    push_byte(8'hA5);
    set_length(32'd5);
    push_byte(8'hA5);
    push_byte(8'h3C);

    // smallest long header
    set_length(32'h0001_0000);
    push_byte(8'h01);
    push_byte(8'h02);
    set_length(32'd4);
    push_byte(8'h02);
    push_byte(8'h02);

    // all-ones length
    set_length(32'hFFFF_FFFF);
    push_byte(8'h80);
    push_byte(8'h7F);
    push_byte(8'h80);
    set_length(32'd4);
    push_byte(8'h7F);

    // zero length: the stream only ends once a reachable length is set
    set_length(32'd0);
    push_byte(8'h55);
    push_byte(8'hAA);
    set_length(32'd3);
    push_byte(8'hAA);

    // two runs back to back
    set_length(32'd4);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);

    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES)
      random_stream(stream_cnt == 0, stream_cnt == 2);

    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d bytes (%0d random streams, %0d length writes), %0d words checked",
             bytes_sent, stream_cnt, length_writes, words_seen);
    $display("Both header forms, saturated runs and literal blocks, long output stall");
    if (errors == 0 && pending == 0)
      $display("rle_byte_compressor_unit verification clean");
    else
      $display("rle_byte_compressor_unit verification failed");
    $finish;
  end

endmodule
